/* design/alist_pkg.sv */
// Shared definitions for the array list engine: operation and status codes,
// field widths and the result record passed from sequencer to output stage.
// No dependencies.
package alist_pkg;

  // Field widths fixed by the external interface
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 9;

  // Default list capacity and limit register reset value
  localparam int DEF_CAPACITY = 256;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 9'd256;

  // Operation codes carried in mode
  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SORT   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // One finished result
  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]   found_index;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
  } res_t;

endpackage

/* design/array_list_engine_top.sv */
// Array list engine: an ordered list of signed 32-bit entries held in one
// memory, with push, pop, insert, erase, find, sort and indexed read.
// Usage:
//   Requests enter on in_valid/in_stall with mode, item_value, position; one
//   result per request leaves on out_valid/out_stall through an output
//   register. cfg_wr_en/cfg_wr_data write the usable limit (saturated into
//   1..CAPACITY); write it only while the block is idle.
//   One request is worked at a time. Push, unused modes and rejected
//   requests finish directly; pop and read wait for one memory read;
//   insert shifts the entries from position up by one place, then writes
//   the new entry; erase shifts the entries above position down; find
//   scans from index 0; sort runs an insertion sort. The single read port
//   of the entry memory moves or compares one entry per cycle.
//   While a result waits in the output register under out_stall, the block
//   accepts and works one more request, then holds it until the register
//   frees up.
//   Reset clears the entry count and sets the limit to 256; the entry
//   memory is not cleared, since only entries below the count are read.
// Depends on alist_pkg, alist_seq, alist_ram.
module array_list_engine_top
  import alist_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [MODE_W-1:0]         mode,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic [POS_W-1:0]          position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] read_value,
  output logic [POS_W-1:0]          found_index,
  output logic [STAT_W-1:0]         status,
  output logic [COUNT_W-1:0]        entry_count,
  input  logic                      cfg_wr_en,
  input  logic [COUNT_W-1:0]        cfg_wr_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [COUNT_W-1:0] usable_limit;
  logic [LW-1:0]      ul_ext, lim_ext;
  logic [CW-1:0]      lim;
  logic               res_valid, res_take, res_load;
  res_t               res;
  logic               mem_wr_en, mem_rd_en;
  logic [IW-1:0]      mem_wr_addr, mem_rd_addr;
  logic [VALUE_W-1:0] mem_wr_data, mem_rd_data;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      usable_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      usable_limit <= cfg_wr_data;
    end
  end

  // Saturate the limit into 1..CAPACITY
  assign ul_ext = LW'(usable_limit);
  always_comb begin
    if (ul_ext == '0) begin
      lim_ext = LW'(1);
    end else if (ul_ext > LW'(CAPACITY)) begin
      lim_ext = LW'(CAPACITY);
    end else begin
      lim_ext = ul_ext;
    end
  end
  assign lim = lim_ext[CW-1:0];

  alist_seq #(
    .CAPACITY(CAPACITY),
    .IW      (IW),
    .CW      (CW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (in_valid),
    .req_stall  (in_stall),
    .mode       (mode),
    .item_value (item_value),
    .position   (position),
    .lim        (lim),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  alist_ram #(
    .DEPTH(CAPACITY),
    .AW   (IW),
    .DW   (VALUE_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  // Output register
  assign res_take = !out_valid || !out_stall;
  assign res_load = res_valid && res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_load) begin
      read_value  <= res.read_value;
      found_index <= res.found_index;
      status      <= res.status;
      entry_count <= res.entry_count;
    end
  end

endmodule

/* design/alist_ram.sv */
// Entry storage for the array list engine: one write port, one read port,
// registered read data. No dependencies.
module alist_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/alist_seq.sv */
// Operation sequencer for the array list engine: holds the entry count and
// walks the entry memory for each request. Depends on alist_pkg.
module alist_seq
  import alist_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int IW = $clog2(CAPACITY),
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst,
  // request side
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [MODE_W-1:0]  mode,
  input  logic [VALUE_W-1:0] item_value,
  input  logic [POS_W-1:0]   position,
  input  logic [CW-1:0]      lim,
  // result side
  output logic               res_valid,
  input  logic               res_take,
  output res_t               res,
  // entry memory
  output logic               mem_wr_en,
  output logic [IW-1:0]      mem_wr_addr,
  output logic [VALUE_W-1:0] mem_wr_data,
  output logic               mem_rd_en,
  output logic [IW-1:0]      mem_rd_addr,
  input  logic [VALUE_W-1:0] mem_rd_data
);

  // Common width for comparisons against narrow or wide port fields
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RDWAIT, S_SHIFT, S_INSFIN, S_FIND,
    S_SOUT, S_SHELD, S_SCMP, S_SPLACE, S_DONE
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      ptr, ptr_next;
  logic [CW-1:0]      rem, rem_next;
  logic [CW-1:0]      j, j_next;
  logic [CW-1:0]      cidx, cidx_next;
  logic [VALUE_W-1:0] held, held_next;
  logic [VALUE_W-1:0] val, val_next;
  logic [IW-1:0]      wr_tgt, wr_tgt_next;
  logic [IW-1:0]      pos_i, pos_i_next;
  logic               pend, pend_next;
  logic               ins, ins_next;
  logic [VALUE_W-1:0] res_rd, res_rd_next;
  logic [POS_W-1:0]   res_found, res_found_next;
  logic [STAT_W-1:0]  res_status, res_status_next;

  logic [LW-1:0] pos_ext, count_ext, lim_ext, cidx_ext;
  logic [CW-1:0] pos_cw, cnt_m1, ptr_p1, ptr_m1, j_m1, j_m2;

  assign pos_ext   = LW'(position);
  assign count_ext = LW'(count);
  assign lim_ext   = LW'(lim);
  assign cidx_ext  = LW'(cidx);
  assign pos_cw    = pos_ext[CW-1:0];
  assign cnt_m1    = count - 1'b1;
  assign ptr_p1    = ptr + 1'b1;
  assign ptr_m1    = ptr - 1'b1;
  assign j_m1      = j - 1'b1;
  assign j_m2      = j - CW'(2);

  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.read_value  = res_rd;
    res.found_index = res_found;
    res.status      = res_status;
    res.entry_count = count_ext[COUNT_W-1:0];
  end

  // Next-state and memory access decode
  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    rem_next        = rem;
    j_next          = j;
    cidx_next       = cidx;
    held_next       = held;
    val_next        = val;
    wr_tgt_next     = wr_tgt;
    pos_i_next      = pos_i;
    pend_next       = pend;
    ins_next        = ins;
    res_rd_next     = res_rd;
    res_found_next  = res_found;
    res_status_next = res_status;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = '0;
    mem_wr_data     = '0;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = ptr[IW-1:0];

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          val_next        = item_value;
          pos_i_next      = pos_ext[IW-1:0];
          res_rd_next     = '0;
          res_found_next  = '0;
          res_status_next = ST_OK;
          pend_next       = 1'b0;
          state_next      = S_DONE;
          case (mode)
            MODE_PUSH: begin
              if (count_ext >= lim_ext) begin
                res_status_next = ST_FULL;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = count[IW-1:0];
                mem_wr_data = item_value;
                count_next  = count + 1'b1;
              end
            end
            MODE_POP: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                count_next  = cnt_m1;
                mem_rd_en   = 1'b1;
                mem_rd_addr = cnt_m1[IW-1:0];
                state_next  = S_RDWAIT;
              end
            end
            MODE_INSERT: begin
              if (pos_ext >= count_ext) begin
                res_status_next = ST_RANGE;
              end else if (count_ext >= lim_ext) begin
                res_status_next = ST_FULL;
              end else begin
                ins_next   = 1'b1;
                ptr_next   = cnt_m1;
                rem_next   = count - pos_cw;
                state_next = S_SHIFT;
              end
            end
            MODE_ERASE: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else if (pos_ext >= count_ext) begin
                res_status_next = ST_RANGE;
              end else begin
                count_next = cnt_m1;
                ins_next   = 1'b0;
                ptr_next   = pos_cw + 1'b1;
                rem_next   = cnt_m1 - pos_cw;
                state_next = S_SHIFT;
              end
            end
            MODE_FIND: begin
              ptr_next   = '0;
              state_next = S_FIND;
            end
            MODE_SORT: begin
              ptr_next   = CW'(1);
              state_next = S_SOUT;
            end
            MODE_READ: begin
              if (pos_ext >= count_ext) begin
                res_status_next = ST_RANGE;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = pos_ext[IW-1:0];
                state_next  = S_RDWAIT;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_RDWAIT: begin
        res_rd_next = mem_rd_data;
        state_next  = S_DONE;
      end

      // Move entries one place: read one, write it back in the next cycle
      S_SHIFT: begin
        if (pend) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = wr_tgt;
          mem_wr_data = mem_rd_data;
        end
        if (rem != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr[IW-1:0];
          pend_next   = 1'b1;
          wr_tgt_next = ins ? ptr_p1[IW-1:0] : ptr_m1[IW-1:0];
          ptr_next    = ins ? ptr_m1 : ptr_p1;
          rem_next    = rem - 1'b1;
        end else begin
          pend_next  = 1'b0;
          state_next = ins ? S_INSFIN : S_DONE;
        end
      end

      S_INSFIN: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos_i;
        mem_wr_data = val;
        count_next  = count + 1'b1;
        state_next  = S_DONE;
      end

      // Linear scan, compare is done in the cycle after the read
      S_FIND: begin
        if (pend && (mem_rd_data == val)) begin
          res_found_next = cidx_ext[POS_W-1:0];
          state_next     = S_DONE;
        end else if (ptr < count) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr[IW-1:0];
          pend_next   = 1'b1;
          cidx_next   = ptr;
          ptr_next    = ptr_p1;
        end else begin
          res_status_next = ST_NOTFOUND;
          state_next      = S_DONE;
        end
      end

      // Insertion sort: ptr is the outer index, j the hole position
      S_SOUT: begin
        if (ptr >= count) begin
          state_next = S_DONE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr[IW-1:0];
          state_next  = S_SHELD;
        end
      end

      S_SHELD: begin
        held_next   = mem_rd_data;
        j_next      = ptr;
        mem_rd_en   = 1'b1;
        mem_rd_addr = ptr_m1[IW-1:0];
        state_next  = S_SCMP;
      end

      S_SCMP: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = j[IW-1:0];
        if ($signed(held) < $signed(mem_rd_data)) begin
          mem_wr_data = mem_rd_data;
          j_next      = j_m1;
          if (j == CW'(1)) begin
            state_next = S_SPLACE;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = j_m2[IW-1:0];
          end
        end else begin
          mem_wr_data = held;
          ptr_next    = ptr_p1;
          state_next  = S_SOUT;
        end
      end

      S_SPLACE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = j[IW-1:0];
        mem_wr_data = held;
        ptr_next    = ptr_p1;
        state_next  = S_SOUT;
      end

      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
    ptr        <= ptr_next;
    rem        <= rem_next;
    j          <= j_next;
    cidx       <= cidx_next;
    held       <= held_next;
    val        <= val_next;
    wr_tgt     <= wr_tgt_next;
    pos_i      <= pos_i_next;
    ins        <= ins_next;
    res_rd     <= res_rd_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
  end

endmodule

/* verif/tb_array_list_engine_top.sv */
// Self-checking testbench for array_list_engine_top: directed list operations,
// limit register corner cases and randomized traffic checked against a local predictor.
// Depends on alist_pkg and the array_list_engine_top RTL.
`timescale 1ns / 100ps

module tb_array_list_engine_top;
  import alist_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
  localparam int LIST_CAP = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [VALUE_W-1:0] FILL_MARK = 32'h5A5A_0FF0;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [MODE_W-1:0]         mode = MODE_PUSH;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic [POS_W-1:0]          position = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] read_value;
  logic [POS_W-1:0]          found_index;
  logic [STAT_W-1:0]         status;
  logic [COUNT_W-1:0]        entry_count;
  logic                      cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]        cfg_wr_data = '0;

  array_list_engine_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .item_value(item_value), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .found_index(found_index),
    .status(status), .entry_count(entry_count),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the list and the limit register
  logic [VALUE_W-1:0] list_mem [LIST_CAP];
  int                 list_count = 0;
  logic [COUNT_W-1:0] limit_reg = LIMIT_RESET;
  int                 peak_count = 0;

  res_t expected_q [$];
  int   errors = 0;
  int   requests_sent = 0;
  int   results_checked = 0;
  int   limit_writes = 0;
  int   burst_left = 0;
  int   cycle_count = 0;

  function automatic int active_limit();
    if (limit_reg == 0) return 1;
    if (limit_reg > LIST_CAP) return LIST_CAP;
    return int'(limit_reg);
  endfunction

  // Apply one request to the shadow list and return the result it should give
  function automatic res_t list_apply(logic [MODE_W-1:0] op, logic [VALUE_W-1:0] val,
                                      logic [POS_W-1:0] pos);
    res_t r;
    int i;
    int j;
    logic [VALUE_W-1:0] held;
    r = '0;
    r.status = ST_OK;
    case (op)
      MODE_PUSH: begin
        if (list_count >= active_limit()) r.status = ST_FULL;
        else begin
          list_mem[list_count] = val;
          list_count++;
        end
      end
      MODE_POP: begin
        if (list_count == 0) r.status = ST_EMPTY;
        else begin
          list_count--;
          r.read_value = list_mem[list_count];
        end
      end
      MODE_INSERT: begin
        if (pos >= list_count) r.status = ST_RANGE;
        else if (list_count >= active_limit()) r.status = ST_FULL;
        else begin
          for (i = list_count; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_count++;
        end
      end
      MODE_ERASE: begin
        if (list_count == 0) r.status = ST_EMPTY;
        else if (pos >= list_count) r.status = ST_RANGE;
        else begin
          list_count--;
          for (i = pos; i < list_count; i++) list_mem[i] = list_mem[i+1];
        end
      end
      MODE_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < list_count; i++) begin
          if (list_mem[i] == val) begin
            r.found_index = i[POS_W-1:0];
            r.status = ST_OK;
            break;
          end
        end
      end
      MODE_SORT: begin
        // stable ascending insertion sort, signed compare
        for (i = 1; i < list_count; i++) begin
          held = list_mem[i];
          j = i;
          while (j > 0 && $signed(held) < $signed(list_mem[j-1])) begin
            list_mem[j] = list_mem[j-1];
            j--;
          end
          list_mem[j] = held;
        end
      end
      MODE_READ: begin
        if (pos >= list_count) r.status = ST_RANGE;
        else r.read_value = list_mem[pos];
      end
      default: ;
    endcase
    r.entry_count = list_count[COUNT_W-1:0];
    if (list_count > peak_count) peak_count = list_count;
    return r;
  endfunction

  // Drive one request; sender idles in bursts with random gaps
  task automatic send_request(logic [MODE_W-1:0] op, logic [VALUE_W-1:0] val,
                              logic [POS_W-1:0] pos);
    int gap;
    res_t want_res;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    @(negedge clk);
    in_valid = 1'b1;
    mode = op;
    item_value = val;
    position = pos;
    do @(posedge clk); while (in_stall);
    want_res = list_apply(op, val, pos);
    expected_q = {expected_q, want_res};
    requests_sent++;
    burst_left--;
  endtask

  // Wait until every request has answered and the block sits idle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [COUNT_W-1:0] lim);
    drain();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = lim;
    @(posedge clk);
    limit_reg = lim;
    limit_writes++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(8) - 4;
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // One random request with mostly meaningful positions and find values
  task automatic random_request();
    int pick;
    logic [MODE_W-1:0] op;
    logic [VALUE_W-1:0] val;
    logic [POS_W-1:0] pos;
    pick = $urandom_range(99);
    if (pick < 30) op = MODE_PUSH;
    else if (pick < 40) op = MODE_POP;
    else if (pick < 55) op = MODE_INSERT;
    else if (pick < 67) op = MODE_ERASE;
    else if (pick < 79) op = MODE_FIND;
    else if (pick < 84) op = MODE_SORT;
    else if (pick < 97) op = MODE_READ;
    else op = MODE_SPARE;
    val = random_value();
    if (op == MODE_FIND && list_count > 0 && $urandom_range(1) == 1)
      val = list_mem[$urandom_range(list_count - 1)];
    if (list_count == 0 || $urandom_range(9) == 0) pos = POS_W'($urandom);
    else pos = POS_W'($urandom_range((list_count > 255) ? 255 : list_count));
    send_request(op, val, pos);
  endtask

  // Empty-list errors, basic operations and index checks
  task automatic test_basic_ops();
    send_request(MODE_POP, 32'h0, 8'd0);
    send_request(MODE_ERASE, 32'h0, 8'd0);
    send_request(MODE_READ, 32'h0, 8'd0);
    send_request(MODE_INSERT, 32'h1234_5678, 8'd0);
    send_request(MODE_FIND, 32'h0, 8'd0);
    send_request(MODE_SORT, 32'h0, 8'd0);
    send_request(MODE_SPARE, 32'hFFFF_FFFF, 8'hFF);
    send_request(MODE_PUSH, 32'h7FFF_FFFF, 8'd0);
    send_request(MODE_PUSH, 32'h8000_0000, 8'hFF);
    send_request(MODE_PUSH, 32'h0000_0000, 8'd0);
    send_request(MODE_PUSH, 32'hFFFF_FFFF, 8'd0);
    send_request(MODE_INSERT, 32'h0000_0005, 8'd0);
    send_request(MODE_INSERT, 32'hFFFF_FFFB, 8'd2);
    // insert at the end is out of range
    send_request(MODE_INSERT, 32'h0000_0009, 8'd6);
    send_request(MODE_READ, 32'h0, 8'd5);
    send_request(MODE_READ, 32'h0, 8'hFF);
    send_request(MODE_FIND, 32'hFFFF_FFFF, 8'd0);
    send_request(MODE_FIND, 32'h1111_1111, 8'd0);
    send_request(MODE_SORT, 32'h0, 8'd0);
    send_request(MODE_READ, 32'h0, 8'd0);
    send_request(MODE_ERASE, 32'h0, 8'd0);
    send_request(MODE_ERASE, 32'h0, 8'hFF);
    send_request(MODE_ERASE, 32'h0, 8'd4);
    send_request(MODE_POP, 32'h0, 8'd0);
  endtask

  // Limit at its extremes and limit lowered below the current count
  task automatic test_limit_corners();
    int k;
    write_limit(9'd0);
    send_request(MODE_PUSH, 32'hCAFE_0001, 8'd0);
    send_request(MODE_PUSH, 32'hCAFE_0002, 8'd0);
    send_request(MODE_INSERT, 32'hCAFE_0003, 8'd0);
    write_limit(9'd511);
    for (k = 0; k < 4; k++) send_request(MODE_PUSH, random_value(), 8'd0);
    write_limit(9'd2);
    send_request(MODE_PUSH, 32'h0000_0042, 8'd0);
    send_request(MODE_INSERT, 32'h0000_0043, 8'd1);
    send_request(MODE_POP, 32'h0, 8'd0);
    send_request(MODE_PUSH, 32'h0000_0044, 8'd0);
    while (list_count > 1) send_request(MODE_POP, 32'h0, 8'd0);
    send_request(MODE_PUSH, 32'h0000_0045, 8'd0);
    send_request(MODE_PUSH, 32'h0000_0046, 8'd0);
    write_limit(9'd1);
    send_request(MODE_READ, 32'h0, 8'd1);
  endtask

  // Random traffic under several limits, one of them above capacity
  task automatic test_random_small();
    logic [COUNT_W-1:0] lims [5];
    int p;
    int k;
    lims = '{9'd3, 9'd17, 9'd32, 9'd8, 9'd300};
    for (p = 0; p < 5; p++) begin
      write_limit(lims[p]);
      for (k = 0; k < 24; k++) random_request();
    end
  endtask

  // Fill to full capacity and work the top index
  task automatic test_full_capacity();
    int k;
    write_limit(9'd256);
    while (list_count < LIST_CAP - 1) begin
      if (list_count > 0 && $urandom_range(7) == 0)
        send_request(MODE_INSERT, random_value(), POS_W'($urandom_range(list_count - 1)));
      else
        send_request(MODE_PUSH, random_value(), 8'd0);
    end
    send_request(MODE_PUSH, FILL_MARK, 8'd0);
    send_request(MODE_PUSH, 32'h0000_0001, 8'd0);
    send_request(MODE_INSERT, 32'h0000_0001, 8'd255);
    send_request(MODE_READ, 32'h0, 8'd255);
    send_request(MODE_FIND, FILL_MARK, 8'd0);
    send_request(MODE_FIND, 32'h8000_0000, 8'd0);
    send_request(MODE_SORT, 32'h0, 8'd0);
    send_request(MODE_READ, 32'h0, 8'd0);
    send_request(MODE_READ, 32'h0, 8'd255);
    send_request(MODE_ERASE, 32'h0, 8'd0);
    send_request(MODE_INSERT, 32'h0BAD_F00D, 8'd254);
    send_request(MODE_ERASE, 32'h0, 8'd255);
    send_request(MODE_PUSH, 32'h0000_0077, 8'd0);
    for (k = 0; k < 20; k++) random_request();
    // limit below a large count
    write_limit(9'd255);
    for (k = 0; k < 10; k++) random_request();
  endtask

  // Receiver stalls in stretches of random density, including stall-free runs
  initial begin : stall_pattern
    int stretch;
    int pct;
    stretch = 0;
    pct = 0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        stretch = $urandom_range(1, 40);
        case ($urandom_range(4))
          0, 1: pct = 0;
          2: pct = 25;
          3: pct = 50;
          default: pct = 90;
        endcase
      end
      stretch--;
      out_stall = ($urandom_range(99) < pct);
    end
  end

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h idx=%0d status=%0d count=%0d",
                 $time, read_value, found_index, status, entry_count);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (read_value !== want.read_value) begin
          errors++;
          $display("%0t: read_value expected %h, got %h", $time, want.read_value, read_value);
        end
        if (found_index !== want.found_index) begin
          errors++;
          $display("%0t: found_index expected %0d, got %0d", $time, want.found_index,
                   found_index);
        end
        if (status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d, got %0d", $time, want.status, status);
        end
        if (entry_count !== want.entry_count) begin
          errors++;
          $display("%0t: entry_count expected %0d, got %0d", $time, want.entry_count,
                   entry_count);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_array_list_engine_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_basic_ops();
    test_limit_corners();
    test_random_small();
    test_full_capacity();
    drain();
    repeat (20) @(posedge clk);
    if (expected_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_q.size());
    end
    $display("run covered %0d requests and %0d checked results over %0d limit writes,",
             requests_sent, results_checked, limit_writes);
    $display("with list sizes up to %0d entries", peak_count);
    if (errors == 0) begin
      $display("tb_array_list_engine_top: done, clean");
    end else begin
      $display("tb_array_list_engine_top: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
design/alist_pkg.sv
design/alist_ram.sv
design/alist_seq.sv
design/array_list_engine_top.sv
verif/tb_array_list_engine_top.sv
